/* src/tcm_pkg.sv */
// ----------------------------------------------------------------------------
// tcm_pkg
// shared types, sizes and codes for the threshold color map table
// ----------------------------------------------------------------------------
package tcm_pkg;

  localparam int ENTRIES    = 16;
  localparam int VALUE_BITS = 16;
  localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_BITS   = $clog2(ENTRIES + 1);
  localparam int COLOR_BITS = 24;

  // operation codes
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_REJECT     = 3'd1;
  localparam logic [2:0] ST_DONE_VALID = 3'd2;
  localparam logic [2:0] ST_DONE_DUP   = 3'd3;
  localparam logic [2:0] ST_NOT_READY  = 3'd4;

  typedef struct packed {
    logic        operation;
    logic [15:0] lower_bound;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] query_value;
  } tcm_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } tcm_rsp_t;

  // entry write broadcast to the cells
  typedef struct packed {
    logic                  en;
    logic [IDX_BITS-1:0]   index;
    logic [VALUE_BITS-1:0] bound;
    logic [COLOR_BITS-1:0] color;
  } tcm_wr_t;

  // token walking down the chain: a lookup or one duplicate probe
  typedef struct packed {
    logic                  valid;
    logic                  is_dup;
    logic [VALUE_BITS-1:0] value;
    logic [IDX_BITS-1:0]   src;
    logic                  found;
    logic [VALUE_BITS-1:0] best;
    logic [COLOR_BITS-1:0] color;
    logic                  dup;
  } tcm_tok_t;

  // fit a 16-bit field to the value width
  function automatic logic [VALUE_BITS-1:0] to_value(input logic [15:0] field);
    logic [31:0] wide;
    wide = {16'b0, field};
    return wide[VALUE_BITS-1:0];
  endfunction

endpackage

/* src/threshold_color_map_table.sv */
// ----------------------------------------------------------------------------
// threshold_color_map_table
// piecewise constant color lookup over a table of threshold entries
// ----------------------------------------------------------------------------
// Requests are taken one at a time. An add that is stored or rejected, and a
// lookup on a table that is not ready, answer through the output register
// alone. A lookup walks a token down the row of ENTRIES cells, one cell per
// cycle, each cell keeping the best bound not above the query, and answers
// when the token leaves the row. The add that fills the last entry launches
// one duplicate probe per entry into the same row, one per cycle, and answers
// once the last probe leaves. Results sit in an output register backed by one
// spare slot, so a new request is taken while a result still waits to be
// picked up. There is no clearing pass: entries are only read once all of
// them were written.
// ----------------------------------------------------------------------------
module threshold_color_map_table
  import tcm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  tcm_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output tcm_rsp_t rsp
);

  // control states
  localparam logic [1:0] S_IDLE = 2'd0;  // ready for a request
  localparam logic [1:0] S_FEED = 2'd1;  // launching duplicate probes
  localparam logic [1:0] S_WAIT = 2'd2;  // tokens still in the row

  logic [1:0]                         state;
  logic [CNT_BITS-1:0]                entry_count;
  logic                               table_ready;
  logic [IDX_BITS-1:0]                feed_idx;
  logic                               dup_acc;
  logic                               skid_valid;
  tcm_rsp_t                           skid;

  logic                               accept;
  logic                               is_lookup;
  logic                               table_full;
  logic                               completing;
  logic                               dup_any;
  logic                               last_probe;
  logic                               rsp_pop;
  logic                               push;
  tcm_rsp_t                           push_data;
  tcm_wr_t                            wr;
  tcm_tok_t                           head;
  tcm_tok_t                           tail;
  logic [ENTRIES-1:0][VALUE_BITS-1:0] bound_taps;

  assign req_ready  = (state == S_IDLE) && !skid_valid;
  assign accept     = req_valid && req_ready;
  assign is_lookup  = (req.operation == OP_LOOKUP);
  assign table_full = (entry_count == CNT_BITS'(ENTRIES));
  assign completing = (entry_count == CNT_BITS'(ENTRIES - 1));
  assign dup_any    = dup_acc | tail.dup;
  assign last_probe = (tail.src == IDX_BITS'(ENTRIES - 1));
  assign rsp_pop    = rsp_valid && rsp_ready;

  // request decode, token launch and result generation
  always_comb begin
    head      = '0;
    wr        = '0;
    push      = 1'b0;
    push_data = '0;

    if (state == S_FEED) begin
      // one duplicate probe per entry
      head.valid  = 1'b1;
      head.is_dup = 1'b1;
      head.value  = bound_taps[feed_idx];
      head.src    = feed_idx;
    end else if (accept) begin
      if (is_lookup) begin
        if (table_ready) begin
          head.valid = 1'b1;
          head.value = to_value(req.query_value);
        end else begin
          push             = 1'b1;
          push_data.status = ST_NOT_READY;
        end
      end else if (table_ready || table_full) begin
        push             = 1'b1;
        push_data.status = ST_REJECT;
      end else begin
        wr.en    = 1'b1;
        wr.index = entry_count[IDX_BITS-1:0];
        wr.bound = to_value(req.lower_bound);
        wr.color = {req.red, req.green, req.blue};
        // the filling add answers after the duplicate sweep
        if (!completing) begin
          push             = 1'b1;
          push_data.status = ST_OK;
        end
      end
    end

    // tokens leaving the end of the row
    if (tail.valid) begin
      if (!tail.is_dup) begin
        // color stays zero when no bound was at or below the query
        push                = 1'b1;
        push_data.status    = ST_OK;
        push_data.red_out   = tail.color[23:16];
        push_data.green_out = tail.color[15:8];
        push_data.blue_out  = tail.color[7:0];
      end else if (last_probe) begin
        push             = 1'b1;
        push_data.status = dup_any ? ST_DONE_DUP : ST_DONE_VALID;
      end
    end
  end

  tcm_chain u_chain (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .tok_in     (head),
    .tok_out    (tail),
    .bound_taps (bound_taps)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      table_ready <= 1'b0;
      feed_idx    <= '0;
      dup_acc     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (wr.en && completing) begin
            state    <= S_FEED;
            feed_idx <= '0;
            dup_acc  <= 1'b0;
          end else if (head.valid) begin
            state <= S_WAIT;
          end
        end
        S_FEED: begin
          feed_idx <= feed_idx + IDX_BITS'(1);
          if (feed_idx == IDX_BITS'(ENTRIES - 1)) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (wr.en) begin
        entry_count <= entry_count + CNT_BITS'(1);
      end

      if (tail.valid) begin
        if (tail.is_dup) begin
          dup_acc <= dup_any;
          if (last_probe) begin
            table_ready <= !dup_any;
            state       <= S_IDLE;
          end
        end else begin
          state <= S_IDLE;
        end
      end
    end
  end

  // output register with one spare slot behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (rsp_pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (rsp_valid && !rsp_pop) begin
        skid_valid <= 1'b1;
      end else begin
        rsp_valid <= 1'b1;
      end
    end else if (rsp_pop) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (rsp_pop) begin
        rsp <= skid;
      end
    end else if (push) begin
      if (rsp_valid && !rsp_pop) begin
        skid <= push_data;
      end else begin
        rsp <= push_data;
      end
    end
  end

endmodule

/* src/tcm_cell.sv */
// ----------------------------------------------------------------------------
// tcm_cell
// one table entry plus one token stage of the compare chain
// ----------------------------------------------------------------------------
module tcm_cell
  import tcm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IDX_BITS-1:0]   cell_index,
  input  tcm_wr_t               wr,
  input  tcm_tok_t              tok_in,
  output tcm_tok_t              tok_out,
  output logic [VALUE_BITS-1:0] bound_tap
);

  logic [VALUE_BITS-1:0] bound;
  logic [COLOR_BITS-1:0] color;
  tcm_tok_t              tok_next;

  always_ff @(posedge clk) begin
    if (wr.en && wr.index == cell_index) begin
      bound <= wr.bound;
      color <= wr.color;
    end
  end

  always_comb begin
    tok_next = tok_in;
    if (tok_in.is_dup) begin
      // probe from another entry with the same bound
      if (tok_in.src != cell_index && tok_in.value == bound) begin
        tok_next.dup = 1'b1;
      end
    end else if (bound <= tok_in.value && (!tok_in.found || bound > tok_in.best)) begin
      tok_next.found = 1'b1;
      tok_next.best  = bound;
      tok_next.color = color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  assign bound_tap = bound;

endmodule

/* src/tcm_chain.sv */
// ----------------------------------------------------------------------------
// tcm_chain
// row of entry cells, tokens step one cell per cycle
// ----------------------------------------------------------------------------
module tcm_chain
  import tcm_pkg::*;
(
  input  logic                                clk,
  input  logic                                rst,
  input  tcm_wr_t                             wr,
  input  tcm_tok_t                            tok_in,
  output tcm_tok_t                            tok_out,
  output logic [ENTRIES-1:0][VALUE_BITS-1:0]  bound_taps
);

  tcm_tok_t link [ENTRIES+1];

  assign link[0] = tok_in;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    tcm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (IDX_BITS'(i)),
      .wr         (wr),
      .tok_in     (link[i]),
      .tok_out    (link[i+1]),
      .bound_tap  (bound_taps[i])
    );
  end

  assign tok_out = link[ENTRIES];

endmodule

/* src/tcm_checker.sv */
// ----------------------------------------------------------------------------
// tcm_checker
// port level checks for the threshold color map table
// ----------------------------------------------------------------------------
module tcm_checker
  import tcm_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_ready,
  input tcm_req_t req,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input tcm_rsp_t rsp
);

  // a stalled result holds its value
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // only known status codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_REJECT ||
                   rsp.status == ST_DONE_VALID || rsp.status == ST_DONE_DUP ||
                   rsp.status == ST_NOT_READY))
    else $error("unknown status code");

  // color only on a successful lookup
  a_color_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |->
      rsp.red_out == 8'd0 && rsp.green_out == 8'd0 && rsp.blue_out == 8'd0)
    else $error("color on a non ok result");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind threshold_color_map_table tcm_checker u_tcm_checker (.*);

/* test/tb_threshold_color_map_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_threshold_color_map_table
// self-checking bench for the threshold color map table
// ----------------------------------------------------------------------------
// One table fill per run, since reset is applied only once. Bounds are
// distinct by default, 1 and top value kept unless overwritten. About one
// run in six overwrites the last bound with a copy of an earlier one, which
// takes the duplicate path. Directed requests cover lookups before the
// table is complete, the completing add, rejected adds and the extreme
// queries. Random traffic follows: mostly lookups that land on, next to or
// away from stored bounds, mixed with adds that must be rejected. A
// scoreboard predicts every response on request acceptance and checks the
// responses in order. Both handshakes see random gaps, plus one long
// response hold-off and full drains of the sender.
// ----------------------------------------------------------------------------
module tb_threshold_color_map_table;
  import tcm_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 950;
  // longest request is the completing add
  localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the table, predicts one response per request
  // --------------------------------------------------------------------------
  class color_map_scoreboard;
    logic [VALUE_BITS-1:0] bound_of[ENTRIES];
    logic [COLOR_BITS-1:0] color_of[ENTRIES];
    int unsigned           filled;
    bit                    usable;
    tcm_rsp_t              expected_rsp[$];
    int unsigned           errors;

    function new();
      filled = 0;
      usable = 0;
      errors = 0;
    endfunction

    function void note_request(tcm_req_t r);
      tcm_rsp_t              exp_rsp;
      logic [VALUE_BITS-1:0] q;
      logic [VALUE_BITS-1:0] best;
      logic [COLOR_BITS-1:0] hit;
      bit                    found;
      bit                    dup;
      int                    i;
      int                    j;
      exp_rsp = '0;
      found   = 0;
      dup     = 0;
      best    = '0;
      hit     = '0;
      q       = r.query_value[VALUE_BITS-1:0];
      if (r.operation == OP_ADD) begin
        if (usable || filled >= ENTRIES) begin
          // full table, whether valid or spoiled by duplicates
          exp_rsp.status = ST_REJECT;
        end else begin
          bound_of[filled] = r.lower_bound[VALUE_BITS-1:0];
          color_of[filled] = {r.red, r.green, r.blue};
          filled++;
          exp_rsp.status = ST_OK;
          if (filled == ENTRIES) begin
            for (i = 0; i < ENTRIES; i++)
              for (j = i + 1; j < ENTRIES; j++)
                if (bound_of[i] == bound_of[j]) dup = 1;
            usable = !dup;
            exp_rsp.status = dup ? ST_DONE_DUP : ST_DONE_VALID;
          end
        end
      end else if (!usable) begin
        exp_rsp.status = ST_NOT_READY;
      end else begin
        // greatest bound not above the query, black when none qualifies
        for (i = 0; i < ENTRIES; i++) begin
          if (bound_of[i] <= q && (!found || bound_of[i] > best)) begin
            best  = bound_of[i];
            hit   = color_of[i];
            found = 1;
          end
        end
        exp_rsp.status = ST_OK;
        {exp_rsp.red_out, exp_rsp.green_out, exp_rsp.blue_out} = hit;
      end
      expected_rsp.push_back(exp_rsp);
    endfunction

    function void flag(string field, logic [7:0] exp_v, logic [7:0] got_v);
      errors++;
      $error("%s: expected %0d, got %0d", field, exp_v, got_v);
    endfunction

    function void check_result(tcm_rsp_t got);
      tcm_rsp_t exp_rsp;
      if (expected_rsp.size() == 0) begin
        errors++;
        $error("response with no request pending, status %0d", got.status);
        return;
      end
      exp_rsp = expected_rsp.pop_front();
      if (got.status !== exp_rsp.status)
        flag("status", 8'(exp_rsp.status), 8'(got.status));
      if (got.red_out !== exp_rsp.red_out)
        flag("red_out", exp_rsp.red_out, got.red_out);
      if (got.green_out !== exp_rsp.green_out)
        flag("green_out", exp_rsp.green_out, got.green_out);
      if (got.blue_out !== exp_rsp.blue_out)
        flag("blue_out", exp_rsp.blue_out, got.blue_out);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals
  // --------------------------------------------------------------------------
  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     rsp_ready = 1'b0;
  tcm_req_t req       = '0;
  logic     req_ready;
  logic     rsp_valid;
  tcm_rsp_t rsp;

  color_map_scoreboard board = new();

  // hold_off: long response stall requested by the stimulus, in cycles
  int unsigned hold_off    = 0;
  int unsigned rsp_stall   = 0;
  int unsigned cycle_count = 0;
  // calm: no gaps on either side while set
  bit          calm        = 0;

  threshold_color_map_table dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // --------------------------------------------------------------------------
  // response side: check accepted responses, then pick next ready
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) board.check_result(rsp);
      if (hold_off > 0) begin
        // long hold-off, counted here so the sender keeps pushing
        hold_off = hold_off - 1;
        rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
        rsp_stall = rsp_stall - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_stall = pick_gap();
        if (rsp_stall > 0) begin
          rsp_stall = rsp_stall - 1;
          rsp_ready <= 1'b0;
        end else begin
          rsp_ready <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------
  // unused fields carry random values so every bit toggles
  function automatic tcm_req_t random_request();
    tcm_req_t r;
    r.operation   = logic'($urandom_range(1));
    r.lower_bound = 16'($urandom_range(65535));
    r.red         = 8'($urandom_range(255));
    r.green       = 8'($urandom_range(255));
    r.blue        = 8'($urandom_range(255));
    r.query_value = 16'($urandom_range(65535));
    return r;
  endfunction

  function automatic tcm_req_t make_add(logic [15:0] bound, logic [7:0] red,
                                        logic [7:0] green, logic [7:0] blue);
    tcm_req_t r;
    r             = random_request();
    r.operation   = OP_ADD;
    r.lower_bound = bound;
    r.red         = red;
    r.green       = green;
    r.blue        = blue;
    return r;
  endfunction

  function automatic tcm_req_t make_lookup(logic [15:0] q);
    tcm_req_t r;
    r             = random_request();
    r.operation   = OP_LOOKUP;
    r.query_value = q;
    return r;
  endfunction

  // offer one request, hold it until taken, then maybe idle
  task automatic send_request(tcm_req_t r);
    int unsigned gap;
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    board.note_request(r);
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender pause until every pending response is back
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (board.expected_rsp.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [15:0] bounds[ENTRIES];
    logic [15:0] cand;
    logic [15:0] q;
    logic [15:0] tmp;
    logic [7:0]  shade[3];
    bit          clash;
    int          k;
    int          j;
    int          n;
    int unsigned roll;
    int unsigned sel;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // distinct bounds, 1 and the top value always among them
    bounds[0] = 16'h0001;
    bounds[1] = 16'hFFFF;
    for (k = 2; k < ENTRIES; k++) begin
      do begin
        cand  = 16'($urandom_range(65534, 2));
        clash = 0;
        for (j = 0; j < k; j++)
          if (bounds[j] == cand) clash = 1;
      end while (clash);
      bounds[k] = cand;
    end
    for (k = ENTRIES - 1; k > 0; k--) begin
      j         = $urandom_range(k);
      tmp       = bounds[k];
      bounds[k] = bounds[j];
      bounds[j] = tmp;
    end
    // now and then spoil the table with a repeated bound
    if ($urandom_range(5) == 0)
      bounds[ENTRIES-1] = bounds[$urandom_range(ENTRIES - 2)];

    // lookups before the table is complete
    send_request(make_lookup(16'h0000));
    send_request(make_lookup(16'hFFFF));

    // fill the table, first entry white, second black; last add completes
    for (k = 0; k < ENTRIES; k++) begin
      if (k == 0) begin
        shade[0] = 8'hFF; shade[1] = 8'hFF; shade[2] = 8'hFF;
      end else if (k == 1) begin
        shade[0] = 8'h00; shade[1] = 8'h00; shade[2] = 8'h00;
      end else begin
        shade[0] = 8'($urandom_range(255));
        shade[1] = 8'($urandom_range(255));
        shade[2] = 8'($urandom_range(255));
      end
      send_request(make_add(bounds[k], shade[0], shade[1], shade[2]));
    end

    // let the completion finish before hammering lookups
    wait_drained();

    // below every bound, lowest bound, top extremes, on and under a bound
    send_request(make_lookup(16'h0000));
    send_request(make_lookup(16'h0001));
    send_request(make_lookup(16'hFFFF));
    send_request(make_lookup(16'hFFFE));
    send_request(make_lookup(bounds[3]));
    send_request(make_lookup(bounds[3] - 16'd1));
    // add on a full table is rejected
    send_request(make_add(16'h0000, 8'hFF, 8'h00, 8'hFF));

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // long response hold-off while requests keep coming
      if (n == 100) begin
        hold_off = 300;
        calm     = 1;
      end
      if (n == 140) calm = 0;
      if (n == 400) wait_drained();
      // steady stretch, no gaps on either side
      if (n == 600) calm = 1;
      if (n == 700) calm = 0;

      roll = $urandom_range(99);
      if (roll < 15) begin
        send_request(make_add(16'($urandom_range(65535)), 8'($urandom_range(255)),
                              8'($urandom_range(255)), 8'($urandom_range(255))));
      end else begin
        sel = $urandom_range(99);
        k   = $urandom_range(ENTRIES - 1);
        if (sel < 40)
          q = bounds[k];
        else if (sel < 60)
          q = bounds[k] + ($urandom_range(1) ? 16'h0001 : 16'hFFFF);
        else
          q = 16'($urandom_range(65535));
        send_request(make_lookup(q));
      end
    end

    // drain and give the block time to show any stray response
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.errors == 0 && board.expected_rsp.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
